// ===== hw/rtl/date_keyed_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Date-keyed priority queue assertion macros
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef DATE_KEYED_PRIORITY_QUEUE_DEFINES_SVH
`define DATE_KEYED_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define DKPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DKPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define DKPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DKPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dkpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Date-keyed priority queue package
// Field widths, status and operation codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package dkpq_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int TAG_IN_W = 32;
  localparam int KEY_W    = YEAR_W + MONTH_W + DAY_W;
  localparam int OCC_W    = 5;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic init_scan;
    logic rd_prev;
    logic rd_head;
    logic wr_new;
    logic wr_shift;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic left_zero;
    logic greater;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/dkpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Date-keyed priority queue controller
// Sequences push insertion scans and pops over the datapath.
// ----------------------------------------------------------------------------
module dkpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  dkpq_pkg::dp_stat_t stat,
  output dkpq_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_CMP,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (!stat.is_pop && !stat.full) begin
          cmd.init_scan = 1'b1;
          state_nxt     = S_SCAN;
        end else if (stat.is_pop && !stat.empty) begin
          cmd.rd_head = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        // With nothing left below the hole, the new entry lands in it.
        if (stat.left_zero) begin
          cmd.wr_new = 1'b1;
          state_nxt  = S_FINISH;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        // Only a strictly later date moves up, so equal dates stay in arrival order.
        if (stat.greater) begin
          cmd.wr_shift = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          cmd.wr_new = 1'b1;
          state_nxt  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/dkpq_dp.sv =====
// ----------------------------------------------------------------------------
// Date-keyed priority queue datapath
// Circular sorted entry memory, pointers, date compare and result register.
// ----------------------------------------------------------------------------
`include "date_keyed_priority_queue_defines.svh"

module dkpq_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_func,
  input  logic [dkpq_pkg::DAY_W-1:0]    in_day,
  input  logic [dkpq_pkg::MONTH_W-1:0]  in_month,
  input  logic [dkpq_pkg::YEAR_W-1:0]   in_year,
  input  logic [dkpq_pkg::TAG_IN_W-1:0] in_tag,
  input  dkpq_pkg::dp_cmd_t             cmd,
  output dkpq_pkg::dp_stat_t            stat,
  input  logic                          out_tready,
  output logic                          out_valid,
  output dkpq_pkg::status_t             out_status,
  output logic [dkpq_pkg::DAY_W-1:0]    out_day,
  output logic [dkpq_pkg::MONTH_W-1:0]  out_month,
  output logic [dkpq_pkg::YEAR_W-1:0]   out_year,
  output logic [dkpq_pkg::TAG_IN_W-1:0] out_tag,
  output logic [dkpq_pkg::OCC_W-1:0]    out_occupancy
);

  localparam int TAG_W = (TAG_BITS < dkpq_pkg::TAG_IN_W) ? TAG_BITS : dkpq_pkg::TAG_IN_W;
  localparam int ENT_W = dkpq_pkg::KEY_W + TAG_W;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  // Entry layout from the top: year, month, day, tag. The top bits form the key.
  logic [ENT_W-1:0] mem [QUEUE_DEPTH];
  logic [ENT_W-1:0] rdata_r;
  logic [ENT_W-1:0] new_ent;
  logic [ENT_W-1:0] wdata;
  logic [PTR_W-1:0] rd_addr;
  logic             rd_en;
  logic             wr_en;

  logic                          func_r;
  logic [dkpq_pkg::DAY_W-1:0]    day_r;
  logic [dkpq_pkg::MONTH_W-1:0]  month_r;
  logic [dkpq_pkg::YEAR_W-1:0]   year_r;
  logic [TAG_W-1:0]              tag_r;

  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] tail_r;
  logic [PTR_W-1:0] cur_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] left_r;
  logic [CNT_W-1:0] count_nxt;

  logic push_ok;
  logic pop_ok;
  dkpq_pkg::status_t status_nxt;

  logic                          out_valid_r;
  dkpq_pkg::status_t             out_status_r;
  logic [dkpq_pkg::DAY_W-1:0]    out_day_r;
  logic [dkpq_pkg::MONTH_W-1:0]  out_month_r;
  logic [dkpq_pkg::YEAR_W-1:0]   out_year_r;
  logic [dkpq_pkg::TAG_IN_W-1:0] out_tag_r;
  logic [dkpq_pkg::OCC_W-1:0]    out_occ_r;

  assign new_ent = {year_r, month_r, day_r, tag_r};
  assign wdata   = cmd.wr_new ? new_ent : rdata_r;
  assign wr_en   = cmd.wr_new | cmd.wr_shift;
  assign rd_en   = cmd.rd_prev | cmd.rd_head;
  assign rd_addr = cmd.rd_head ? head_r : ptr_prev(cur_r);

  assign stat.is_pop    = (func_r == dkpq_pkg::FUNC_POP);
  assign stat.full      = (count_r == CNT_FULL);
  assign stat.empty     = (count_r == '0);
  assign stat.left_zero = (left_r == '0);
  assign stat.greater   = (rdata_r[ENT_W-1 -: dkpq_pkg::KEY_W] > new_ent[ENT_W-1 -: dkpq_pkg::KEY_W]);
  assign stat.out_free  = !out_valid_r || out_tready;

  assign push_ok = !stat.is_pop && !stat.full;
  assign pop_ok  = stat.is_pop && !stat.empty;

  always_comb begin
    priority if (push_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
    priority if (stat.is_pop && stat.empty) begin
      status_nxt = dkpq_pkg::ST_EMPTY;
    end else if (!stat.is_pop && stat.full) begin
      status_nxt = dkpq_pkg::ST_FULL;
    end else begin
      status_nxt = dkpq_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_r] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        if (push_ok) begin
          tail_r <= ptr_next(tail_r);
        end
        if (pop_ok) begin
          head_r <= ptr_next(head_r);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r  <= in_func;
      day_r   <= in_day;
      month_r <= in_month;
      year_r  <= in_year;
      tag_r   <= in_tag[TAG_W-1:0];
    end
    // The hole starts just past the tail and walks down as later entries move up.
    if (cmd.init_scan) begin
      cur_r  <= tail_r;
      left_r <= count_r;
    end else if (cmd.wr_shift) begin
      cur_r  <= ptr_prev(cur_r);
      left_r <= left_r - 1'b1;
    end
    if (cmd.finish) begin
      out_status_r <= status_nxt;
      out_occ_r    <= dkpq_pkg::OCC_W'(count_nxt);
      if (pop_ok) begin
        out_year_r  <= rdata_r[ENT_W-1 -: dkpq_pkg::YEAR_W];
        out_month_r <= rdata_r[TAG_W+dkpq_pkg::DAY_W +: dkpq_pkg::MONTH_W];
        out_day_r   <= rdata_r[TAG_W +: dkpq_pkg::DAY_W];
        out_tag_r   <= dkpq_pkg::TAG_IN_W'(rdata_r[TAG_W-1:0]);
      end else begin
        out_year_r  <= '0;
        out_month_r <= '0;
        out_day_r   <= '0;
        out_tag_r   <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_day       = out_day_r;
  assign out_month     = out_month_r;
  assign out_year      = out_year_r;
  assign out_tag       = out_tag_r;
  assign out_occupancy = out_occ_r;

  `DKPQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_FULL, "entry count above depth")
  `DKPQ_ASSERT(a_empty_ptrs, clk, rst_n, (count_r == '0) |-> (head_r == tail_r), "head and tail apart on empty queue")
  `DKPQ_ASSERT(a_shift_later, clk, rst_n, cmd.wr_shift |-> (stat.greater && !stat.full), "shift of an entry that is not later")
  `DKPQ_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid_r, "finished word not presented")

endmodule

// ===== hw/rtl/date_keyed_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Date-keyed priority queue
// Bounded sorted queue of dated entries; push inserts in date order, pop
// returns the earliest entry. Equal dates leave first-in first-out.
// ----------------------------------------------------------------------------
// Input words: in_tuser selects push (0) or pop (1); in_tdata carries the date
// and tag of a push. Each input word yields exactly one output word with a
// status in out_tuser and the popped entry plus the occupancy in out_tdata.
// One word is processed at a time; in_tready is high while the block is idle.
// A pop or a rejected push passes the decide and finish states before
// out_tvalid rises. A push walks a hole down from the tail past each later
// entry: each step reads one entry from the single-port entry memory, waits
// for its registered data, compares dates and writes it one slot higher. The
// scan stops at the first entry that is not later, or when every held entry
// has moved, and the new entry is written into the hole. in_tready returns
// as the result is registered. The result sits in an output register; a
// stalled receiver holds it, and the block may accept the next word
// meanwhile, finishing it once the register is taken. Reset empties the
// queue and drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module date_keyed_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // day[4:0], month[8:5], year[22:9], tag[54:23], pad
  input  logic        in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // day[4:0], month[8:5], year[22:9], tag[54:23],
                                  // occupancy[59:55], pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  dkpq_pkg::dp_cmd_t  cmd;
  dkpq_pkg::dp_stat_t stat;
  dkpq_pkg::status_t  status;

  logic [dkpq_pkg::DAY_W-1:0]    o_day;
  logic [dkpq_pkg::MONTH_W-1:0]  o_month;
  logic [dkpq_pkg::YEAR_W-1:0]   o_year;
  logic [dkpq_pkg::TAG_IN_W-1:0] o_tag;
  logic [dkpq_pkg::OCC_W-1:0]    o_occ;

  dkpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dkpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_tuser),
    .in_day        (in_tdata[4:0]),
    .in_month      (in_tdata[8:5]),
    .in_year       (in_tdata[22:9]),
    .in_tag        (in_tdata[54:23]),
    .cmd           (cmd),
    .stat          (stat),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_status    (status),
    .out_day       (o_day),
    .out_month     (o_month),
    .out_year      (o_year),
    .out_tag       (o_tag),
    .out_occupancy (o_occ)
  );

  assign out_tdata = {4'b0000, o_occ, o_tag, o_year, o_month, o_day};
  assign out_tuser = status;

endmodule

// ===== bench/tb_date_keyed_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date-keyed priority queue testbench
// Drives push and pop words with random gaps, keeps its own sorted list of
// dated entries to predict each reply, and checks every reply field against
// that prediction while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_date_keyed_priority_queue;

  localparam int DEPTH          = 16;
  localparam int TOTAL_ITEMS    = 1400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  // Packed so that the low bits match the entry part of in_tdata and out_tdata.
  typedef struct packed {
    logic [31:0] tag;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } entry_t;

  typedef struct {
    logic        func;
    entry_t      ent;
    int unsigned gap;
  } stim_t;

  typedef struct {
    dkpq_pkg::status_t status;
    entry_t            ent;
    logic [4:0]        occupancy;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  stim_t  stim_words[$];
  entry_t sorted_entries[$];
  reply_t expected_replies[$];

  int unsigned stim_total = 0;
  int unsigned accepted_words = 0;
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  logic        stalled = 1'b0;
  bit          tx_calm = 1'b0;
  entry_t      last_ent = '0;

  always #6 clk = ~clk;

  date_keyed_priority_queue #(
    .QUEUE_DEPTH(DEPTH),
    .TAG_BITS   (32)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic logic [22:0] date_order(entry_t e);
    return {e.year, e.month, e.day};
  endfunction

  // Sorted insert after every equal date keeps ties first-in first-out.
  task automatic predict_reply(stim_t w);
    reply_t r;
    int     pos;
    r.status = dkpq_pkg::ST_OK;
    r.ent    = '0;
    if (w.func == dkpq_pkg::FUNC_PUSH) begin
      if (sorted_entries.size() >= DEPTH) begin
        r.status = dkpq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_entries.size() &&
               date_order(sorted_entries[pos]) <= date_order(w.ent))
          pos++;
        sorted_entries.insert(pos, w.ent);
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        r.status = dkpq_pkg::ST_EMPTY;
      end else begin
        r.ent = sorted_entries.pop_front();
      end
    end
    r.occupancy = 5'(sorted_entries.size());
    expected_replies.push_back(r);
  endtask

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic add_word(logic func, entry_t ent);
    stim_t w;
    w.func = func;
    w.ent  = ent;
    w.gap  = draw_gap(tx_calm);
    stim_words.push_back(w);
  endtask

  task automatic add_push(int d, int m, int y, logic [31:0] t);
    entry_t e;
    e.day   = 5'(d);
    e.month = 4'(m);
    e.year  = 14'(y);
    e.tag   = t;
    add_word(dkpq_pkg::FUNC_PUSH, e);
  endtask

  // Mostly a few nearby years so that dates collide; sometimes the full
  // legal range, sometimes raw bits outside the calendar.
  function automatic entry_t rand_entry();
    entry_t  e;
    int unsigned pick;
    pick  = $urandom_range(0, 99);
    e.tag = $urandom;
    if (pick < 20) begin
      e.day   = last_ent.day;
      e.month = last_ent.month;
      e.year  = last_ent.year;
    end else if (pick < 70) begin
      e.day   = 5'($urandom_range(1, 31));
      e.month = 4'($urandom_range(1, 12));
      e.year  = 14'(2000 + $urandom_range(0, 3));
    end else if (pick < 85) begin
      e.day   = 5'($urandom_range(1, 31));
      e.month = 4'($urandom_range(1, 12));
      e.year  = 14'($urandom_range(0, 9999));
    end else begin
      e.day   = 5'($urandom_range(0, 31));
      e.month = 4'($urandom_range(0, 15));
      e.year  = 14'($urandom_range(0, 16383));
    end
    return e;
  endfunction

  // Driver: one word at a time from the stimulus queue, each after its own gap.
  stim_t       drv_word;
  bit          drv_loaded = 1'b0;
  int unsigned drv_hold = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      drv_loaded = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_reply(drv_word);
        accepted_words++;
        drv_loaded = 1'b0;
      end
      if (!drv_loaded && stim_words.size() != 0) begin
        drv_word   = stim_words.pop_front();
        drv_hold   = drv_word.gap;
        drv_loaded = 1'b1;
      end
      if (drv_loaded && drv_hold == 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, drv_word.ent};
        in_tuser  <= drv_word.func;
      end else begin
        in_tvalid <= 1'b0;
        if (drv_loaded) drv_hold--;
      end
    end
  end

  // Monitor: checks each reply word, then holds out_tready low for a random gap, which may be zero.
  int unsigned rx_stall = 0;
  int unsigned rx_mode_left = 0;
  bit          rx_calm = 1'b0;
  reply_t      want;
  entry_t      got_ent;
  logic [4:0]  got_occ;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_ent = out_tdata[54:0];
        got_occ = out_tdata[59:55];
        if (expected_replies.size() == 0) begin
          $error("reply word with no pending request: tuser %0d tdata %h",
                 out_tuser, out_tdata);
          err_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            err_count++;
          end
          if (got_ent.day !== want.ent.day) begin
            $error("out_day: expected %0d, got %0d", want.ent.day, got_ent.day);
            err_count++;
          end
          if (got_ent.month !== want.ent.month) begin
            $error("out_month: expected %0d, got %0d", want.ent.month, got_ent.month);
            err_count++;
          end
          if (got_ent.year !== want.ent.year) begin
            $error("out_year: expected %0d, got %0d", want.ent.year, got_ent.year);
            err_count++;
          end
          if (got_ent.tag !== want.ent.tag) begin
            $error("out_tag: expected %h, got %h", want.ent.tag, got_ent.tag);
            err_count++;
          end
          if (got_occ !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got_occ);
            err_count++;
          end
        end
        if (rx_mode_left == 0) begin
          rx_calm      = ($urandom_range(0, 3) == 0);
          rx_mode_left = $urandom_range(20, 80);
        end else begin
          rx_mode_left--;
        end
        rx_stall = draw_gap(rx_calm);
      end
      if (rx_stall != 0) begin
        out_tready <= 1'b0;
        rx_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      stalled <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned block_len;
    int unsigned push_pct;
    entry_t      e;

    // Directed part: empty pop, calendar and raw-bit extremes, a run of equal
    // dates, filling the store, a push into a full store, then drains.
    add_word(dkpq_pkg::FUNC_POP, '0);
    add_push(31, 12, 9999, 32'hFFFF_FFFF);
    add_push(1, 1, 0, 32'h0000_0000);
    add_push(0, 0, 0, 32'h0000_0001);
    add_push(31, 15, 16383, 32'h8000_0000);
    add_push(15, 6, 2024, 32'h0000_0100);
    add_push(15, 6, 2024, 32'h0000_0101);
    add_push(15, 6, 2024, 32'h0000_0102);
    add_push(15, 6, 2024, 32'h0000_0103);
    add_push(1, 12, 2023, 32'hA5A5_A5A5);
    add_push(31, 1, 2024, 32'h5A5A_5A5A);
    add_push(14, 6, 2024, 32'h1234_5678);
    add_push(16, 6, 2024, 32'h8765_4321);
    add_push(15, 5, 2024, 32'hDEAD_BEEF);
    add_push(15, 7, 2024, 32'hCAFE_F00D);
    add_push(1, 1, 2025, 32'h0F0F_0F0F);
    add_push(30, 11, 2000, 32'hF0F0_F0F0);
    add_push(2, 2, 2002, 32'h7777_7777);
    repeat (6) add_word(dkpq_pkg::FUNC_POP, '0);

    // Random part: phases lean toward pushing or popping so the store swings
    // between empty and full; pops carry junk in the ignored fields.
    while (stim_words.size() < TOTAL_ITEMS) begin
      block_len = $urandom_range(30, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      repeat (block_len) begin
        if ($urandom_range(0, 99) < push_pct) begin
          e = rand_entry();
          last_ent = e;
          add_word(dkpq_pkg::FUNC_PUSH, e);
        end else begin
          e = 55'({$urandom, $urandom});
          add_word(dkpq_pkg::FUNC_POP, e);
        end
      end
    end
    stim_total = stim_words.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (!stalled && !(accepted_words == stim_total && expected_replies.size() == 0))
      @(negedge clk);
    if (!stalled) repeat (DRAIN_CYCLES) @(negedge clk);

    if (!stalled && err_count == 0 && expected_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
